// ----- rtl/core/erll_pkg.sv -----
// Shared types and constants for the extent run-list lookup block.
// Used by erll_front, erll_queue, erll_back and extent_run_list_lookup_top.
// No dependencies.
package erll_pkg;

    // Field widths and limits.
    localparam int unsigned VCN_W           = 64;
    localparam int unsigned MAX_FIELD_BYTES = 8;
    localparam int unsigned CFG_INDEX_W     = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOW_VCN  = 2'd0,
        REG_HIGH_VCN = 2'd1
    } cfg_reg_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BOUNDS    = 2'd2,
        ST_MALFORMED = 2'd3
    } status_t;

    // Parser phase of the front end.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_LENGTH = 2'd2,
        PH_OFFSET = 2'd3
    } phase_t;

    // Kind of record handed from the front end to the back end.
    typedef enum logic [2:0] {
        REC_NONE      = 3'd0,
        REC_RUN       = 3'd1,
        REC_NOT_FOUND = 3'd2,
        REC_BOUNDS    = 3'd3,
        REC_MALFORMED = 3'd4
    } rec_kind_t;

    // One input item.
    typedef struct packed {
        logic [7:0]       run_byte;
        logic             start_req;
        logic [VCN_W-1:0] target_vcn;
    } in_item_t;

    // One result item.
    typedef struct packed {
        status_t          status;
        logic [VCN_W-1:0] physical_cluster;
        logic [VCN_W-1:0] clusters_left;
        logic             sparse;
    } out_item_t;

    // Classified record in the queue between front and back end.
    typedef struct packed {
        logic             start;
        logic [VCN_W-1:0] target;
        logic [VCN_W-1:0] low;
        rec_kind_t        kind;
        logic [VCN_W-1:0] run_length;
        logic [VCN_W-1:0] run_offset;
        logic             sparse;
    } rec_t;

endpackage

// ----- rtl/core/erll_front.sv -----
// Front end of the run-list lookup: parses run-list bytes into run records.
// Depends on erll_pkg; feeds erll_queue.
module erll_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    input  logic                          byte_stall,
    input  erll_pkg::in_item_t            byte_item,
    input  logic [erll_pkg::VCN_W-1:0]    low_vcn,
    input  logic [erll_pkg::VCN_W-1:0]    high_vcn,
    output logic                          push,
    output erll_pkg::rec_t                push_rec
);

    erll_pkg::phase_t               phase_reg, phase_next;
    logic [3:0]                     len_bytes_reg, len_bytes_next;
    logic [3:0]                     off_bytes_reg, off_bytes_next;
    logic [2:0]                     idx_reg, idx_next;
    logic [erll_pkg::VCN_W-1:0]     len_acc_reg, len_acc_next;
    logic [erll_pkg::VCN_W-1:0]     off_acc_reg, off_acc_next;

    logic                           accept;
    logic                           start;
    logic                           bounds_bad;
    erll_pkg::phase_t               eff_phase;
    logic [7:0]                     b;
    logic [3:0]                     hdr_lo;
    logic [3:0]                     hdr_hi;
    logic                           hdr_zero;
    logic                           hdr_bad;
    logic [3:0]                     idx_sum;
    logic                           len_last;
    logic                           off_last;
    logic [erll_pkg::VCN_W-1:0]     len_ins;
    logic [erll_pkg::VCN_W-1:0]     off_ins;
    logic [erll_pkg::VCN_W-1:0]     off_ext;

    // Shared decode of the current byte.
    assign accept     = byte_valid && !byte_stall;
    assign start      = byte_item.start_req;
    assign b          = byte_item.run_byte;
    assign bounds_bad = (byte_item.target_vcn < low_vcn) || (byte_item.target_vcn > high_vcn);
    assign eff_phase  = start ? erll_pkg::PH_HEADER : phase_reg;
    assign hdr_lo     = b[3:0];
    assign hdr_hi     = b[7:4];
    assign hdr_zero   = (b == 8'd0);
    assign hdr_bad    = (hdr_lo > 4'(erll_pkg::MAX_FIELD_BYTES))
                     || (hdr_hi > 4'(erll_pkg::MAX_FIELD_BYTES));
    assign idx_sum    = {1'b0, idx_reg} + 4'd1;
    assign len_last   = (idx_sum >= len_bytes_reg);
    assign off_last   = (idx_sum >= off_bytes_reg);

    // Byte lane insertion; the final offset byte also sign-extends upward.
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            if (idx_reg == 3'(j))
            begin
                len_ins[j*8 +: 8] = b;
                off_ins[j*8 +: 8] = b;
                off_ext[j*8 +: 8] = b;
            end
            else
            begin
                len_ins[j*8 +: 8] = len_acc_reg[j*8 +: 8];
                off_ins[j*8 +: 8] = off_acc_reg[j*8 +: 8];
                off_ext[j*8 +: 8] = (3'(j) > idx_reg) ? {8{b[7]}} : off_acc_reg[j*8 +: 8];
            end
        end
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (start && bounds_bad)
            begin
                phase_next = erll_pkg::PH_IDLE;
            end
            else
            begin
                case (eff_phase)
                    erll_pkg::PH_IDLE:
                    begin
                        phase_next = erll_pkg::PH_IDLE;
                    end
                    erll_pkg::PH_HEADER:
                    begin
                        if (hdr_zero || hdr_bad)
                            phase_next = erll_pkg::PH_IDLE;
                        else if (hdr_lo != 4'd0)
                            phase_next = erll_pkg::PH_LENGTH;
                        else
                            phase_next = erll_pkg::PH_OFFSET;
                    end
                    erll_pkg::PH_LENGTH:
                    begin
                        if (len_last)
                            phase_next = (off_bytes_reg != 4'd0) ? erll_pkg::PH_OFFSET
                                                                 : erll_pkg::PH_HEADER;
                    end
                    erll_pkg::PH_OFFSET:
                    begin
                        if (off_last)
                            phase_next = erll_pkg::PH_HEADER;
                    end
                    default:
                    begin
                        phase_next = erll_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Field accumulators and the record handed to the queue.
    always_comb
    begin
        len_bytes_next      = len_bytes_reg;
        off_bytes_next      = off_bytes_reg;
        idx_next            = idx_reg;
        len_acc_next        = len_acc_reg;
        off_acc_next        = off_acc_reg;
        push                = 1'b0;
        push_rec            = '0;
        push_rec.kind       = erll_pkg::REC_NONE;
        push_rec.start      = start;
        push_rec.target     = byte_item.target_vcn;
        push_rec.low        = low_vcn;
        push_rec.run_length = len_acc_reg;
        if (accept)
        begin
            if (start && bounds_bad)
            begin
                push          = 1'b1;
                push_rec.kind = erll_pkg::REC_BOUNDS;
            end
            else
            begin
                case (eff_phase)
                    erll_pkg::PH_IDLE:
                    begin
                        push = 1'b0;
                    end
                    erll_pkg::PH_HEADER:
                    begin
                        if (hdr_zero)
                        begin
                            push          = 1'b1;
                            push_rec.kind = erll_pkg::REC_NOT_FOUND;
                        end
                        else if (hdr_bad)
                        begin
                            push          = 1'b1;
                            push_rec.kind = erll_pkg::REC_MALFORMED;
                        end
                        else
                        begin
                            // A start header still tells the back end to reload.
                            push           = start;
                            len_bytes_next = hdr_lo;
                            off_bytes_next = hdr_hi;
                            idx_next       = 3'd0;
                            len_acc_next   = '0;
                            off_acc_next   = '0;
                        end
                    end
                    erll_pkg::PH_LENGTH:
                    begin
                        len_acc_next = len_ins;
                        idx_next     = len_last ? 3'd0 : idx_sum[2:0];
                        if (len_last && (off_bytes_reg == 4'd0))
                        begin
                            // Run without an offset field is sparse.
                            push                = 1'b1;
                            push_rec.kind       = erll_pkg::REC_RUN;
                            push_rec.run_length = len_ins;
                            push_rec.run_offset = '0;
                            push_rec.sparse     = 1'b1;
                        end
                    end
                    erll_pkg::PH_OFFSET:
                    begin
                        off_acc_next = off_ins;
                        idx_next     = idx_sum[2:0];
                        if (off_last)
                        begin
                            idx_next            = 3'd0;
                            push                = 1'b1;
                            push_rec.kind       = erll_pkg::REC_RUN;
                            push_rec.run_offset = off_ext;
                            push_rec.sparse     = 1'b0;
                        end
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end
        end
    end

    // Parser registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= erll_pkg::PH_IDLE;
            len_bytes_reg <= 4'd0;
            off_bytes_reg <= 4'd0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            len_bytes_reg <= len_bytes_next;
            off_bytes_reg <= off_bytes_next;
            idx_reg       <= idx_next;
        end
    end

    // Accumulators are fully reloaded at each header.
    always_ff @(posedge clk)
    begin
        len_acc_reg <= len_acc_next;
        off_acc_reg <= off_acc_next;
    end

endmodule

// ----- rtl/core/erll_queue.sv -----
// Short record queue that decouples the parser from the run evaluator.
// Depends on erll_pkg for the record type.
module erll_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  erll_pkg::rec_t push_rec,
    input  logic           pop,
    output logic           head_valid,
    output erll_pkg::rec_t head_rec,
    output logic           full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    erll_pkg::rec_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill-count update, with explicit wrap for any depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    // The parser is held off while the queue is full, so nothing is dropped.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");

endmodule

// ----- rtl/core/erll_back.sv -----
// Back end of the run-list lookup: evaluates run records against the target.
// Depends on erll_pkg; fed by erll_queue, drives the result channel.
module erll_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  erll_pkg::rec_t       head_rec,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_stall,
    output erll_pkg::out_item_t  res_item
);

    // Lookup state.
    logic                        active_reg, active_next;
    logic [erll_pkg::VCN_W-1:0]  wanted_reg, wanted_next;
    logic [erll_pkg::VCN_W-1:0]  base_reg, base_next;
    logic [erll_pkg::VCN_W-1:0]  phys_reg, phys_next;

    // Middle stage: decided result, arithmetic not yet finished.
    logic                        p_valid_reg, p_valid_next;
    erll_pkg::status_t           p_status_reg, p_status_next;
    logic [erll_pkg::VCN_W-1:0]  p_phys_reg, p_phys_next;
    logic [erll_pkg::VCN_W-1:0]  p_delta_reg, p_delta_next;
    logic [erll_pkg::VCN_W-1:0]  p_len_reg, p_len_next;
    logic                        p_sparse_reg, p_sparse_next;

    // Output register.
    logic                        res_valid_reg, res_valid_next;
    erll_pkg::out_item_t         res_item_reg, res_item_next;

    logic                        eff_active;
    logic [erll_pkg::VCN_W-1:0]  eff_wanted;
    logic [erll_pkg::VCN_W-1:0]  eff_base;
    logic [erll_pkg::VCN_W-1:0]  eff_phys;
    logic                        borrow;
    logic [erll_pkg::VCN_W-1:0]  delta;
    logic                        hit;
    logic                        is_run;
    logic                        is_end;
    logic [erll_pkg::VCN_W-1:0]  phys_sum;
    logic                        needs_slot;
    logic                        out_ready;
    logic                        p_ready;
    logic                        emit;
    logic                        found;

    // A start record reloads the lookup state before its own kind is applied.
    assign eff_active = head_rec.start ? 1'b1 : active_reg;
    assign eff_wanted = head_rec.start ? head_rec.target : wanted_reg;
    assign eff_base   = head_rec.start ? head_rec.low : base_reg;
    assign eff_phys   = head_rec.start ? '0 : phys_reg;

    // Run containment: base <= target and target - base < length.
    assign {borrow, delta} = {1'b0, eff_wanted} - {1'b0, eff_base};
    assign hit       = !borrow && (delta < head_rec.run_length);
    assign phys_sum  = eff_phys + head_rec.run_offset;
    assign is_run    = (head_rec.kind == erll_pkg::REC_RUN);
    assign is_end    = (head_rec.kind == erll_pkg::REC_NOT_FOUND)
                    || (head_rec.kind == erll_pkg::REC_BOUNDS)
                    || (head_rec.kind == erll_pkg::REC_MALFORMED);

    // Handshake between the stages.
    assign out_ready  = !res_valid_reg || !res_stall;
    assign p_ready    = !p_valid_reg || out_ready;
    assign needs_slot = eff_active && (head_rec.kind != erll_pkg::REC_NONE);
    assign pop        = head_valid && (!needs_slot || p_ready);
    assign found      = eff_active && is_run && hit;
    assign emit       = pop && eff_active && (is_end || (is_run && hit));

    // Lookup state update on every popped record.
    always_comb
    begin
        active_next = active_reg;
        wanted_next = wanted_reg;
        base_next   = base_reg;
        phys_next   = phys_reg;
        if (pop)
        begin
            active_next = eff_active && !(is_end || (is_run && hit));
            wanted_next = eff_wanted;
            base_next   = is_run ? eff_base + head_rec.run_length : eff_base;
            phys_next   = is_run ? phys_sum : eff_phys;
        end
    end

    // Middle stage load.
    always_comb
    begin
        p_valid_next  = p_valid_reg;
        p_status_next = p_status_reg;
        p_phys_next   = p_phys_reg;
        p_delta_next  = p_delta_reg;
        p_len_next    = p_len_reg;
        p_sparse_next = p_sparse_reg;
        if (p_ready)
            p_valid_next = emit;
        if (emit)
        begin
            case (head_rec.kind)
                erll_pkg::REC_RUN:       p_status_next = erll_pkg::ST_FOUND;
                erll_pkg::REC_NOT_FOUND: p_status_next = erll_pkg::ST_NOT_FOUND;
                erll_pkg::REC_BOUNDS:    p_status_next = erll_pkg::ST_BOUNDS;
                erll_pkg::REC_MALFORMED: p_status_next = erll_pkg::ST_MALFORMED;
                default:                 p_status_next = erll_pkg::ST_NOT_FOUND;
            endcase
            p_phys_next   = found ? phys_sum : '0;
            p_delta_next  = found ? delta : '0;
            p_len_next    = found ? head_rec.run_length : '0;
            p_sparse_next = found && head_rec.sparse;
        end
    end

    // Output stage: final adds for the physical cluster and clusters left.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_item_next  = res_item_reg;
        if (out_ready)
            res_valid_next = p_valid_reg;
        if (out_ready && p_valid_reg)
        begin
            res_item_next.status           = p_status_reg;
            res_item_next.physical_cluster = p_sparse_reg ? '0 : p_phys_reg + p_delta_reg;
            res_item_next.clusters_left    = p_len_reg - p_delta_reg;
            res_item_next.sparse           = p_sparse_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            p_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            p_valid_reg   <= p_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        wanted_reg   <= wanted_next;
        base_reg     <= base_next;
        phys_reg     <= phys_next;
        p_status_reg <= p_status_next;
        p_phys_reg   <= p_phys_next;
        p_delta_reg  <= p_delta_next;
        p_len_reg    <= p_len_next;
        p_sparse_reg <= p_sparse_next;
        res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // Results other than found carry zero fields.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_item.status != erll_pkg::ST_FOUND))
        |-> ((res_item.physical_cluster == '0) && (res_item.clusters_left == '0)
             && !res_item.sparse))
        else $error("non-found result with nonzero fields");

    // A sparse hit has no physical location and always leaves clusters.
    a_sparse_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.sparse)
        |-> ((res_item.status == erll_pkg::ST_FOUND) && (res_item.physical_cluster == '0)))
        else $error("sparse result with a physical cluster");

endmodule

// ----- rtl/core/extent_run_list_lookup_top.sv -----
// Extent run-list lookup: decodes a compressed run list and resolves one virtual cluster.
// Byte channel in, result channel out; one item per cycle sustained unless stalled.
//
// Usage: feed run-list bytes on the byte channel (byte_valid / byte_stall /
// byte_item), one byte per transfer. The first byte of a list carries
// start_req = 1 and the target virtual cluster; it is also the first run
// header. Each lookup gives at most one result on the result channel
// (res_valid / res_stall / res_item): found, not found at the terminator,
// outside the configured bounds, or malformed header. Bytes after a result
// are dropped until the next start.
// Throughput: one byte per cycle while byte_stall is low. A parser, a
// four-entry record queue and a two-stage run evaluator run concurrently, so
// bytes keep flowing while a finished result waits in the output register.
// Result path: the record for the byte that decides a result is queued at the
// transfer edge, then evaluated into the middle stage, then finished by the
// final add into the output register; earlier records or res_stall can delay it.
// Stall: when res_stall holds, results pile up in the evaluator and then the
// queue; byte_stall rises only once the queue is full.
// Reset: rst_n clears the parser, queue and result valid, and both bounds
// registers to zero. Write the bounds with cfg_write while the block is idle.
module extent_run_list_lookup_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_valid,
    output logic                                byte_stall,
    input  erll_pkg::in_item_t                  byte_item,
    output logic                                res_valid,
    input  logic                                res_stall,
    output erll_pkg::out_item_t                 res_item,
    input  logic                                cfg_write,
    input  logic [erll_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [erll_pkg::VCN_W-1:0]          cfg_data
);

    logic [erll_pkg::VCN_W-1:0]  low_vcn_reg, low_vcn_next;
    logic [erll_pkg::VCN_W-1:0]  high_vcn_reg, high_vcn_next;
    logic                        q_push;
    erll_pkg::rec_t              q_push_rec;
    logic                        q_pop;
    logic                        q_head_valid;
    erll_pkg::rec_t              q_head_rec;
    logic                        q_full;

    // Bounds register writes; unknown indexes are ignored.
    always_comb
    begin
        low_vcn_next  = low_vcn_reg;
        high_vcn_next = high_vcn_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                erll_pkg::REG_LOW_VCN:  low_vcn_next  = cfg_data;
                erll_pkg::REG_HIGH_VCN: high_vcn_next = cfg_data;
                default:
                begin
                    low_vcn_next  = low_vcn_reg;
                    high_vcn_next = high_vcn_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_vcn_reg  <= '0;
            high_vcn_reg <= '0;
        end
        else
        begin
            low_vcn_reg  <= low_vcn_next;
            high_vcn_reg <= high_vcn_next;
        end
    end

    // The byte channel is held off only by a full record queue.
    assign byte_stall = q_full;

    // Parser.
    erll_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .low_vcn    (low_vcn_reg),
        .high_vcn   (high_vcn_reg),
        .push       (q_push),
        .push_rec   (q_push_rec)
    );

    // Record queue.
    erll_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_rec   (q_push_rec),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_rec   (q_head_rec),
        .full       (q_full)
    );

    // Run evaluator and result register.
    erll_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_rec   (q_head_rec),
        .pop        (q_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

endmodule
